>>> sv/sgri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgri_pkg
// Shared types, constants and helpers of the Sobel gradient / row depth
// integrator.
// ----------------------------------------------------------------------------
package sgri_pkg;

  localparam int LUMA_W             = 8;
  localparam int CODE_W             = 8;
  localparam int LW_W               = 11;
  localparam int GRAD_W             = 11;
  localparam int GRAD_LIMIT         = 127;
  localparam int MIN_LINE_WIDTH     = 3;
  localparam int DEF_MAX_LINE_WIDTH = 1024;
  localparam int LINE_WIDTH_RESET   = 320;
  localparam int DEPTH_BIAS         = 128;
  localparam int DEPTH_MAX          = 255;
  localparam int QUEUE_DEPTH        = 4;
  localparam int APB_ADDR_W         = 3;
  localparam int APB_DATA_W         = 32;

  localparam logic [CODE_W-1:0] NEUTRAL_CODE = 8'd127;

  // Register index, taken from the word address bit of paddr
  localparam logic REG_LINE_WIDTH = 1'b0;

  typedef struct packed {
    logic [LUMA_W-1:0] above;
    logic [LUMA_W-1:0] center;
    logic [LUMA_W-1:0] below;
  } column_t;

  typedef struct packed {
    logic [CODE_W-1:0]        q_code;
    logic [CODE_W-1:0]        p_code;
    logic signed [CODE_W-1:0] p_val;
  } grad_t;

  typedef struct packed {
    logic [CODE_W-1:0] q_code;
    logic [CODE_W-1:0] p_code;
    logic [CODE_W-1:0] depth;
    logic              line_end;
    logic              last_of_run;
  } result_t;

  // Divide by 8 truncating toward zero, then clamp to +-GRAD_LIMIT
  function automatic logic signed [CODE_W-1:0] div8_clamp(
    input logic signed [GRAD_W-1:0] v
  );
    logic signed [GRAD_W-1:0] t;
    logic signed [GRAD_W-1:0] lim;
    lim = $signed(GRAD_W'(GRAD_LIMIT));
    if (v < 0) begin
      t = (v + $signed(GRAD_W'(7))) >>> 3;
    end else begin
      t = v >>> 3;
    end
    if (t > lim) begin
      t = lim;
    end else if (t < -lim) begin
      t = -lim;
    end
    return t[CODE_W-1:0];
  endfunction

endpackage

>>> sv/sgri_gradient.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgri_gradient
// 3x3 Sobel gx / gy over three columns, scaled by 1/8, clamped and encoded.
// ----------------------------------------------------------------------------
module sgri_gradient (
  input  sgri_pkg::column_t col_left,
  input  sgri_pkg::column_t col_mid,
  input  sgri_pkg::column_t col_right,
  output sgri_pkg::grad_t   grad
);
  import sgri_pkg::*;

  logic signed [GRAD_W-1:0] la, lc, lb, ma, mb, ra, rc, rb;
  logic signed [GRAD_W-1:0] gx, gy;
  logic signed [CODE_W-1:0] p_s, q_s;

  assign la = $signed(GRAD_W'(col_left.above));
  assign lc = $signed(GRAD_W'(col_left.center));
  assign lb = $signed(GRAD_W'(col_left.below));
  assign ma = $signed(GRAD_W'(col_mid.above));
  assign mb = $signed(GRAD_W'(col_mid.below));
  assign ra = $signed(GRAD_W'(col_right.above));
  assign rc = $signed(GRAD_W'(col_right.center));
  assign rb = $signed(GRAD_W'(col_right.below));

  // Both sums stay within +-1020, so 11 bits hold every intermediate
  assign gx = (ra - la) + ((rc - lc) <<< 1) + (rb - lb);
  assign gy = (lb + (mb <<< 1) + rb) - (la + (ma <<< 1) + ra);

  assign p_s = div8_clamp(gx);
  assign q_s = div8_clamp(gy);

  assign grad.p_val  = p_s;
  assign grad.p_code = CODE_W'(p_s) + NEUTRAL_CODE;
  assign grad.q_code = CODE_W'(q_s) + NEUTRAL_CODE;

endmodule

>>> sv/sgri_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgri_result_fifo
// Small result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module sgri_result_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_n,
  input  sgri_pkg::result_t push0,
  input  sgri_pkg::result_t push1,
  input  logic              pop,
  output sgri_pkg::result_t head,
  output logic              not_empty,
  output logic              space2
);
  import sgri_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  result_t       mem_r [QUEUE_DEPTH];
  logic [IW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [IW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign wr_ptr_p1  = wr_ptr_r + IW'(1);
  assign wr_ptr_nxt = wr_ptr_r + IW'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + IW'(pop);
  assign count_nxt  = count_r + CW'(push_n) - CW'(pop);

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign space2    = (count_r <= CW'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (push_n != 2'd0 && IW'(i) == wr_ptr_r) begin
        mem_r[i] <= push0;
      end else if (push_n == 2'd2 && IW'(i) == wr_ptr_p1) begin
        mem_r[i] <= push1;
      end
    end
  end

endmodule

>>> sv/sobel_gradient_row_depth_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_gradient_row_depth_integrator
// Streaming Sobel gradient encoder with a per-line running depth integral.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel column per transfer (luma above, center, below).
//   out_* : result transfers carrying q_code, p_code, depth, line_end and
//           last_of_run. Column 0 gives no result, every later column gives
//           the result of the column before it, and the last column of a line
//           gives a second result for itself (line_end set).
//   cfg_* : APB-style register port; line_width at address 0.
// Order: an accepted column is held in the input register until the queue
//   has room for two results; it is then processed into the result queue.
// Throughput: one column per cycle while the result queue has room;
//   the extra result at each line end is balanced by column 0 giving none,
//   so a line of W columns gives W results and the output keeps pace.
// Reset: the column counter and depth sum clear, line_width returns to 320,
//   the result queue empties. No clearing pass is needed.
// Stall: when out_ready is low results wait in a four-entry queue; in_ready
//   drops once the queue cannot take the two results of another column.
// ----------------------------------------------------------------------------
module sobel_gradient_row_depth_integrator #(
  parameter int MAX_LINE_WIDTH = sgri_pkg::DEF_MAX_LINE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sgri_pkg::LUMA_W-1:0]     in_luma_above,
  input  logic [sgri_pkg::LUMA_W-1:0]     in_luma_center,
  input  logic [sgri_pkg::LUMA_W-1:0]     in_luma_below,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sgri_pkg::CODE_W-1:0]     out_q_code,
  output logic [sgri_pkg::CODE_W-1:0]     out_p_code,
  output logic [sgri_pkg::CODE_W-1:0]     out_depth,
  output logic                            out_line_end,
  output logic                            out_last_of_run,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sgri_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [sgri_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [sgri_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import sgri_pkg::*;

  localparam int CNT_W = $clog2(MAX_LINE_WIDTH);
  localparam int SUM_W = CNT_W + 9;
  localparam int CMP_W = (CNT_W + 1 > LW_W) ? CNT_W + 1 : LW_W;

  // Input register and column state
  logic                    s1_valid_r, s1_valid_nxt;
  column_t                 s1_col_r;
  column_t                 win0_r, win1_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [LW_W-1:0]         line_width_r;

  logic                    in_xfer, adv, cfg_wr, fifo_space2;
  logic [CMP_W-1:0]        w_eff, lw_ext, cnt_inc;
  logic                    last, has_first, inner;
  grad_t                   grad;
  logic signed [CODE_W-1:0] p_sel;
  logic signed [SUM_W-1:0] p2, sum_new, z;
  logic [CODE_W-1:0]       depth_clamped;
  result_t                 r_pix, r_end, push0;
  logic [1:0]              push_n;
  result_t                 head;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_LINE_WIDTH) begin
      cfg_prdata = APB_DATA_W'(line_width_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LW_W'(LINE_WIDTH_RESET);
    end else if (cfg_wr && cfg_paddr[2] == REG_LINE_WIDTH) begin
      line_width_r <= cfg_pwdata[LW_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  assign adv      = s1_valid_r & fifo_space2;
  assign in_ready = ~s1_valid_r | fifo_space2;
  assign in_xfer  = in_valid & in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_col_r.above  <= in_luma_above;
      s1_col_r.center <= in_luma_center;
      s1_col_r.below  <= in_luma_below;
    end
  end

  // --------------------------------------------------------------------------
  // Column position and gradient
  // --------------------------------------------------------------------------
  assign lw_ext  = CMP_W'(line_width_r);
  assign cnt_inc = CMP_W'(cnt_r) + CMP_W'(1);

  always_comb begin
    w_eff = lw_ext;
    if (lw_ext < CMP_W'(MIN_LINE_WIDTH)) begin
      w_eff = CMP_W'(MIN_LINE_WIDTH);
    end else if (lw_ext > CMP_W'(MAX_LINE_WIDTH)) begin
      w_eff = CMP_W'(MAX_LINE_WIDTH);
    end
  end

  // A shrunk width mid-line also ends the line here
  assign last      = (cnt_inc >= w_eff);
  assign has_first = (cnt_r != '0);
  assign inner     = (cnt_r > CNT_W'(1));

  sgri_gradient u_gradient (
    .col_left  (win1_r),
    .col_mid   (win0_r),
    .col_right (s1_col_r),
    .grad      (grad)
  );

  // --------------------------------------------------------------------------
  // Depth integral
  // --------------------------------------------------------------------------
  assign p_sel   = inner ? grad.p_val : '0;
  assign p2      = {{(SUM_W - CODE_W - 1){p_sel[CODE_W-1]}}, p_sel, 1'b0};
  assign sum_new = sum_r + p2;
  assign z       = sum_new + $signed(SUM_W'(DEPTH_BIAS));

  always_comb begin
    if (z < 0) begin
      depth_clamped = '0;
    end else if (z > $signed(SUM_W'(DEPTH_MAX))) begin
      depth_clamped = CODE_W'(DEPTH_MAX);
    end else begin
      depth_clamped = z[CODE_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Result assembly
  // --------------------------------------------------------------------------
  always_comb begin
    r_pix.q_code      = inner ? grad.q_code : NEUTRAL_CODE;
    r_pix.p_code      = inner ? grad.p_code : NEUTRAL_CODE;
    r_pix.depth       = depth_clamped;
    r_pix.line_end    = 1'b0;
    r_pix.last_of_run = ~last;

    r_end.q_code      = NEUTRAL_CODE;
    r_end.p_code      = NEUTRAL_CODE;
    r_end.depth       = depth_clamped;
    r_end.line_end    = 1'b1;
    r_end.last_of_run = 1'b1;
  end

  assign push0  = has_first ? r_pix : r_end;
  assign push_n = adv ? (2'(has_first) + 2'(last)) : 2'd0;

  // --------------------------------------------------------------------------
  // State update
  // --------------------------------------------------------------------------
  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    if (adv) begin
      if (last) begin
        cnt_nxt = '0;
        sum_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
        sum_nxt = sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Window taps are only read once both hold columns of the current line
  always_ff @(posedge clk) begin
    if (adv && !last) begin
      win1_r <= win0_r;
      win0_r <= s1_col_r;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  sgri_result_fifo u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (push0),
    .push1     (r_end),
    .pop       (out_valid & out_ready),
    .head      (head),
    .not_empty (out_valid),
    .space2    (fifo_space2)
  );

  assign out_q_code      = head.q_code;
  assign out_p_code      = head.p_code;
  assign out_depth       = head.depth;
  assign out_line_end    = head.line_end;
  assign out_last_of_run = head.last_of_run;

`ifndef SYNTHESIS
  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last) |=> (cnt_r == '0 && sum_r == '0))
    else $error("line end did not restart the column state");

  a_end_is_border: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_end) |->
      (out_last_of_run && out_q_code == NEUTRAL_CODE && out_p_code == NEUTRAL_CODE))
    else $error("line end result is not a neutral final result");

  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_col_r)))
    else $error("stalled column lost from the input register");

  a_first_col_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && cnt_r == '0) |-> (push_n == 2'd0))
    else $error("column zero produced a result");
`endif

endmodule
